/* design/qsve_pkg.sv */
// qsve_pkg: constants, codes and arithmetic helpers of the qubit state vector engine
// no dependencies; imported by qubit_state_vector_engine

package qsve_pkg;

    // sizes
    localparam int MAX_QUBITS    = 10;
    localparam int AMP_FRAC_BITS = 30;
    localparam int ADDR_W        = MAX_QUBITS;
    localparam int DEPTH         = 1 << MAX_QUBITS;
    localparam int N_W           = $clog2(MAX_QUBITS + 1);
    localparam int IDX_CMP_W     = 5;
    localparam int ACC_W         = 64 + MAX_QUBITS;
    localparam int GACC_W        = 66;
    localparam int AMP_W         = 64;

    // q1.31 conversion shifts
    localparam int SH_R = (2 * AMP_FRAC_BITS >= 31) ? 2 * AMP_FRAC_BITS - 31 : 0;
    localparam int SH_L = (2 * AMP_FRAC_BITS >= 31) ? 0 : 31 - 2 * AMP_FRAC_BITS;

    localparam logic [31:0] Q31_ONE = 32'h8000_0000;
    localparam logic [AMP_W-1:0] AMP_ONE = {32'(1 << AMP_FRAC_BITS), 32'd0};

    // stream layout
    localparam int IN_W  = 320;
    localparam int OUT_W = 40;
    localparam int OFS_OP   = 0;
    localparam int OFS_TGT  = 3;
    localparam int OFS_CTL  = 7;
    localparam int OFS_C00  = 11;
    localparam int OFS_C01  = 75;
    localparam int OFS_C10  = 139;
    localparam int OFS_C11  = 203;
    localparam int OFS_RND  = 267;
    localparam int OFS_BAS  = 299;

    // operation codes
    localparam logic [2:0] OP_INIT  = 3'd0;
    localparam logic [2:0] OP_GATE  = 3'd1;
    localparam logic [2:0] OP_CGATE = 3'd2;
    localparam logic [2:0] OP_MEAS  = 3'd3;
    localparam logic [2:0] OP_PROB  = 3'd4;

    // status codes
    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_BAD_QUBIT = 3'd1;
    localparam logic [2:0] STS_CTL_EQ    = 3'd2;
    localparam logic [2:0] STS_BAD_RAND  = 3'd3;
    localparam logic [2:0] STS_NO_OUTCOME = 3'd4;

    // register index
    localparam logic REG_QUBIT_COUNT = 1'b0;

    typedef logic signed [GACC_W-1:0] gacc_t;

    // round half up to the amplitude grid, then saturate to 32 bits
    function automatic logic [31:0] rnd_sat(input gacc_t v);
        gacc_t t;
        t = (v + (GACC_W'(1) <<< (AMP_FRAC_BITS - 1))) >>> AMP_FRAC_BITS;
        if (t > $signed(66'sh0_7FFF_FFFF)) begin
            return 32'h7FFF_FFFF;
        end else if (t < -$signed(66'sh0_8000_0000)) begin
            return 32'h8000_0000;
        end else begin
            return t[31:0];
        end
    endfunction

    // squared magnitude sum to q1.31, truncated, one or more clamps
    function automatic logic [31:0] to_q31(input logic [ACC_W-1:0] v);
        logic [ACC_W-1:0] t;
        t = (v >> SH_R) << SH_L;
        if (v >= (ACC_W'(1) << (2 * AMP_FRAC_BITS))) begin
            return Q31_ONE;
        end else begin
            return t[31:0];
        end
    endfunction

endpackage

/* design/qsve_ram.sv */
// qsve_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module qsve_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/qubit_state_vector_engine.sv */
// qubit_state_vector_engine: state vector simulator over one amplitude ram
// depends on qsve_pkg and qsve_ram
//
//  channel   dir  handshake         payload
//  s_        in   s_tvalid/tready   s_tdata: operation, target, control, coeff x4, random, basis
//  m_        out  m_tvalid/tready   m_tdata: status, measured bit, probability
//  apb       in   psel/penable      register 0 qubit_count at address 0
//
// one item at a time; n is the active qubit count.
// gate: 2^(n-1) pairs, each via G_RA, G_RB, G_P0 to G_P5; a control-skipped pair only G_RA.
// measure: sum pass of M_RD, M_MUL, M_ACC per entry, 32 root steps, then R_RD, R_LD, the
//   divide steps and R_WR per kept entry, R_RD only per cleared one; probability P_RD to P_SUM.
// initialize and reset sweep all 1024 ram entries one per cycle, no beat taken meanwhile.
// a result enters the output register once free; the next beat can come before it is read.

module qubit_state_vector_engine (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // operation, target_index, control_index, coeff_00, coeff_01, coeff_10, coeff_11,
    // random_draw, basis_index (lowest first), zero pad
    input  logic [qsve_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // status, measured_bit, probability (lowest first), zero pad
    output logic [qsve_pkg::OUT_W-1:0] m_tdata,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    import qsve_pkg::*;

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_G_RA  = 5'd2;
    localparam logic [4:0] S_G_RB  = 5'd3;
    localparam logic [4:0] S_G_P0  = 5'd4;
    localparam logic [4:0] S_G_P1  = 5'd5;
    localparam logic [4:0] S_G_P2  = 5'd6;
    localparam logic [4:0] S_G_P3  = 5'd7;
    localparam logic [4:0] S_G_P4  = 5'd8;
    localparam logic [4:0] S_G_P5  = 5'd9;
    localparam logic [4:0] S_M_RD  = 5'd10;
    localparam logic [4:0] S_M_MUL = 5'd11;
    localparam logic [4:0] S_M_ACC = 5'd12;
    localparam logic [4:0] S_M_DEC = 5'd13;
    localparam logic [4:0] S_SQRT  = 5'd14;
    localparam logic [4:0] S_R_RD  = 5'd15;
    localparam logic [4:0] S_R_LD  = 5'd16;
    localparam logic [4:0] S_R_DIV = 5'd17;
    localparam logic [4:0] S_R_WR  = 5'd18;
    localparam logic [4:0] S_P_RD  = 5'd19;
    localparam logic [4:0] S_P_MUL = 5'd20;
    localparam logic [4:0] S_P_SUM = 5'd21;
    localparam logic [4:0] S_DONE  = 5'd22;

    logic [4:0]        state_reg;
    logic [3:0]        qc_reg;
    logic              clr_op_reg;

    // item fields
    logic [2:0]        op_reg;
    logic [3:0]        tgt_reg;
    logic [3:0]        ctl_reg;
    logic [AMP_W-1:0]  c00_reg, c01_reg, c10_reg, c11_reg;
    logic [31:0]       rnd_reg;
    logic [15:0]       bas_reg;

    // result
    logic [2:0]        sts_reg;
    logic              bit_reg;
    logic [31:0]       prob_reg;
    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_data_reg;

    // datapath
    logic [ADDR_W-1:0] idx_reg;
    logic [4:0]        step_reg;
    logic [AMP_W-1:0]  a_reg, b_reg, res0_reg;
    gacc_t             acc_re_reg, acc_im_reg;
    logic [ACC_W-1:0]  msum_reg;
    logic signed [63:0] pr_rr_reg, pr_ii_reg, pr_ri_reg, pr_ir_reg;
    logic              outc_reg;
    logic [63:0]       sq_x_reg, sq_r_reg, sq_b_reg;
    logic [31:0]       s_reg;
    logic [31:0]       dre_r_reg, dre_n_reg, dre_q_reg;
    logic [31:0]       dim_r_reg, dim_n_reg, dim_q_reg;
    logic              dre_ovf_reg, dim_ovf_reg, dre_neg_reg, dim_neg_reg;

    // ram port
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [AMP_W-1:0]  ram_wdata, ram_rdata;

    qsve_ram #(.WIDTH(AMP_W), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // input field views
    logic [2:0]  in_op;
    logic [3:0]  in_tgt, in_ctl;
    logic [31:0] in_rnd;
    logic [15:0] in_bas;
    assign in_op  = s_tdata[OFS_OP +: 3];
    assign in_tgt = s_tdata[OFS_TGT +: 4];
    assign in_ctl = s_tdata[OFS_CTL +: 4];
    assign in_rnd = s_tdata[OFS_RND +: 32];
    assign in_bas = s_tdata[OFS_BAS +: 16];

    // active qubit count and state size
    logic [N_W-1:0]    n_act;
    logic [ADDR_W:0]   size;
    logic              last_pair, last_ent;
    always_comb begin
        if (qc_reg == 4'd0) begin
            n_act = N_W'(1);
        end else if (32'(qc_reg) > MAX_QUBITS) begin
            n_act = N_W'(MAX_QUBITS);
        end else begin
            n_act = N_W'(qc_reg);
        end
    end
    assign size      = (ADDR_W + 1)'(1) << n_act;
    assign last_pair = (idx_reg == ADDR_W'((size >> 1) - 1'b1));
    assign last_ent  = (idx_reg == ADDR_W'(size - 1'b1));

    // pair addresses: insert a zero at the target bit
    logic [ADDR_W-1:0] tb, cb, lowm, ia, ib;
    logic              cskip;
    assign tb    = ADDR_W'(1) << tgt_reg;
    assign cb    = ADDR_W'(1) << ctl_reg;
    assign lowm  = tb - 1'b1;
    assign ia    = ((idx_reg & ~lowm) << 1) | (idx_reg & lowm);
    assign ib    = ia | tb;
    assign cskip = (op_reg == OP_CGATE) && ((ia & cb) == '0);

    // complex multiplier operands
    logic [AMP_W-1:0] mul_x, mul_y;
    always_comb begin
        case (state_reg)
            S_G_P0:  begin mul_x = c00_reg;   mul_y = a_reg;     end
            S_G_P1:  begin mul_x = c01_reg;   mul_y = b_reg;     end
            S_G_P2:  begin mul_x = c10_reg;   mul_y = a_reg;     end
            S_G_P3:  begin mul_x = c11_reg;   mul_y = b_reg;     end
            S_M_MUL: begin mul_x = ram_rdata; mul_y = ram_rdata; end
            S_P_MUL: begin mul_x = ram_rdata; mul_y = ram_rdata; end
            default: begin mul_x = '0;        mul_y = '0;        end
        endcase
    end

    logic signed [31:0] x_re, x_im, y_re, y_im;
    assign x_re = mul_x[63:32];
    assign x_im = mul_x[31:0];
    assign y_re = mul_y[63:32];
    assign y_im = mul_y[31:0];

    // four partial products, registered
    always_ff @(posedge aclk) begin
        pr_rr_reg <= x_re * y_re;
        pr_ii_reg <= x_im * y_im;
        pr_ri_reg <= x_re * y_im;
        pr_ir_reg <= x_im * y_re;
    end

    gacc_t psum_re, psum_im;
    logic [63:0] mag;
    assign psum_re = GACC_W'(pr_rr_reg) - GACC_W'(pr_ii_reg);
    assign psum_im = GACC_W'(pr_ri_reg) + GACC_W'(pr_ir_reg);
    assign mag     = $unsigned(pr_rr_reg) + $unsigned(pr_ii_reg);

    // measure decision
    logic [31:0] p0, pout;
    logic        outc;
    assign p0   = to_q31(msum_reg);
    assign outc = !(rnd_reg < p0);
    assign pout = outc ? (Q31_ONE - p0) : p0;

    // square root step
    logic [63:0] sq_rb;
    assign sq_rb = sq_r_reg + sq_b_reg;

    // renormalize load
    logic signed [31:0] l_re, l_im;
    logic [31:0]        m_re, m_im;
    logic [62:0]        n_re, n_im;
    logic [63:0]        s_hi;
    assign l_re = ram_rdata[63:32];
    assign l_im = ram_rdata[31:0];
    assign m_re = l_re[31] ? 32'(-l_re) : 32'(l_re);
    assign m_im = l_im[31] ? 32'(-l_im) : 32'(l_im);
    assign n_re = {m_re, 31'd0} + 63'(s_reg >> 1);
    assign n_im = {m_im, 31'd0} + 63'(s_reg >> 1);
    assign s_hi = {s_reg, 32'd0};

    // restoring divider steps, two lanes
    logic [32:0] dre_r2, dim_r2;
    logic        dre_ge, dim_ge;
    assign dre_r2 = {dre_r_reg, dre_n_reg[31]};
    assign dim_r2 = {dim_r_reg, dim_n_reg[31]};
    assign dre_ge = dre_r2 >= {1'b0, s_reg};
    assign dim_ge = dim_r2 >= {1'b0, s_reg};

    // quotient to signed part with saturation
    logic [31:0] w_re, w_im;
    always_comb begin
        if (dre_neg_reg) begin
            w_re = (dre_ovf_reg || dre_q_reg > Q31_ONE) ? Q31_ONE : (~dre_q_reg + 1'b1);
        end else begin
            w_re = (dre_ovf_reg || dre_q_reg[31]) ? 32'h7FFF_FFFF : dre_q_reg;
        end
        if (dim_neg_reg) begin
            w_im = (dim_ovf_reg || dim_q_reg > Q31_ONE) ? Q31_ONE : (~dim_q_reg + 1'b1);
        end else begin
            w_im = (dim_ovf_reg || dim_q_reg[31]) ? 32'h7FFF_FFFF : dim_q_reg;
        end
    end

    logic ent_match;
    assign ent_match = (((idx_reg & tb) != '0) == outc_reg);

    // ram port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = ia;
        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = (idx_reg == '0) ? AMP_ONE : '0;
            end
            S_G_RA: begin
                ram_re = !cskip;
            end
            S_G_RB: begin
                ram_re    = 1'b1;
                ram_raddr = ib;
            end
            S_G_P4: begin
                ram_we    = 1'b1;
                ram_waddr = ia;
                ram_wdata = res0_reg;
            end
            S_G_P5: begin
                ram_we    = 1'b1;
                ram_waddr = ib;
                ram_wdata = {rnd_sat(acc_re_reg), rnd_sat(acc_im_reg)};
            end
            S_M_RD: begin
                ram_re = 1'b1;
            end
            S_R_RD: begin
                ram_re    = ent_match;
                ram_raddr = idx_reg;
                ram_we    = !ent_match;
            end
            S_R_WR: begin
                ram_we    = 1'b1;
                ram_wdata = {w_re, w_im};
            end
            S_P_RD: begin
                ram_re    = 1'b1;
                ram_raddr = bas_reg[ADDR_W-1:0];
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            clr_op_reg <= 1'b0;
            idx_reg    <= '0;
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (&idx_reg) begin
                        state_reg <= clr_op_reg ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg     <= in_op;
                        tgt_reg    <= in_tgt;
                        ctl_reg    <= in_ctl;
                        c00_reg    <= s_tdata[OFS_C00 +: 64];
                        c01_reg    <= s_tdata[OFS_C01 +: 64];
                        c10_reg    <= s_tdata[OFS_C10 +: 64];
                        c11_reg    <= s_tdata[OFS_C11 +: 64];
                        rnd_reg    <= in_rnd;
                        bas_reg    <= in_bas;
                        sts_reg    <= STS_OK;
                        bit_reg    <= 1'b0;
                        prob_reg   <= '0;
                        idx_reg    <= '0;
                        msum_reg   <= '0;
                        clr_op_reg <= 1'b0;
                        case (in_op)
                            OP_INIT: begin
                                clr_op_reg <= 1'b1;
                                state_reg  <= S_CLEAR;
                            end
                            OP_GATE, OP_CGATE: begin
                                if (IDX_CMP_W'(in_tgt) >= IDX_CMP_W'(n_act) ||
                                    (in_op == OP_CGATE &&
                                     IDX_CMP_W'(in_ctl) >= IDX_CMP_W'(n_act))) begin
                                    sts_reg   <= STS_BAD_QUBIT;
                                    state_reg <= S_DONE;
                                end else if (in_op == OP_CGATE && in_ctl == in_tgt) begin
                                    sts_reg   <= STS_CTL_EQ;
                                    state_reg <= S_DONE;
                                end else begin
                                    state_reg <= S_G_RA;
                                end
                            end
                            OP_MEAS: begin
                                if (IDX_CMP_W'(in_tgt) >= IDX_CMP_W'(n_act)) begin
                                    sts_reg   <= STS_BAD_QUBIT;
                                    state_reg <= S_DONE;
                                end else if (in_rnd > Q31_ONE) begin
                                    sts_reg   <= STS_BAD_RAND;
                                    state_reg <= S_DONE;
                                end else begin
                                    state_reg <= S_M_RD;
                                end
                            end
                            OP_PROB: begin
                                if (17'(in_bas) < 17'(size)) begin
                                    state_reg <= S_P_RD;
                                end else begin
                                    state_reg <= S_DONE;
                                end
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                // gate over pairs
                S_G_RA: begin
                    if (cskip) begin
                        idx_reg <= idx_reg + 1'b1;
                        if (last_pair) begin
                            state_reg <= S_DONE;
                        end
                    end else begin
                        state_reg <= S_G_RB;
                    end
                end
                S_G_RB: begin
                    a_reg     <= ram_rdata;
                    state_reg <= S_G_P0;
                end
                S_G_P0: begin
                    b_reg     <= ram_rdata;
                    state_reg <= S_G_P1;
                end
                S_G_P1: begin
                    acc_re_reg <= psum_re;
                    acc_im_reg <= psum_im;
                    state_reg  <= S_G_P2;
                end
                S_G_P2: begin
                    acc_re_reg <= acc_re_reg + psum_re;
                    acc_im_reg <= acc_im_reg + psum_im;
                    state_reg  <= S_G_P3;
                end
                S_G_P3: begin
                    res0_reg   <= {rnd_sat(acc_re_reg), rnd_sat(acc_im_reg)};
                    acc_re_reg <= psum_re;
                    acc_im_reg <= psum_im;
                    state_reg  <= S_G_P4;
                end
                S_G_P4: begin
                    acc_re_reg <= acc_re_reg + psum_re;
                    acc_im_reg <= acc_im_reg + psum_im;
                    state_reg  <= S_G_P5;
                end
                S_G_P5: begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= last_pair ? S_DONE : S_G_RA;
                end
                // measure: sum of p0
                S_M_RD: begin
                    state_reg <= S_M_MUL;
                end
                S_M_MUL: begin
                    state_reg <= S_M_ACC;
                end
                S_M_ACC: begin
                    msum_reg <= msum_reg + ACC_W'(mag);
                    idx_reg  <= idx_reg + 1'b1;
                    state_reg <= last_pair ? S_M_DEC : S_M_RD;
                end
                S_M_DEC: begin
                    outc_reg <= outc;
                    idx_reg  <= '0;
                    step_reg <= '0;
                    sq_x_reg <= {1'b0, pout, 31'd0};
                    sq_r_reg <= '0;
                    sq_b_reg <= 64'd1 << 62;
                    if (pout == '0) begin
                        sts_reg   <= STS_NO_OUTCOME;
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sq_x_reg >= sq_rb) begin
                        sq_x_reg <= sq_x_reg - sq_rb;
                        sq_r_reg <= (sq_r_reg >> 1) + sq_b_reg;
                    end else begin
                        sq_r_reg <= sq_r_reg >> 1;
                    end
                    sq_b_reg <= sq_b_reg >> 2;
                    step_reg <= step_reg + 1'b1;
                    if (&step_reg) begin
                        state_reg <= S_R_RD;
                    end
                end
                // collapse and renormalize
                S_R_RD: begin
                    s_reg <= sq_r_reg[31:0];
                    if (ent_match) begin
                        state_reg <= S_R_LD;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                        if (last_ent) begin
                            bit_reg   <= outc_reg;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_R_LD: begin
                    dre_neg_reg <= l_re[31];
                    dim_neg_reg <= l_im[31];
                    dre_ovf_reg <= {1'b0, n_re} >= s_hi;
                    dim_ovf_reg <= {1'b0, n_im} >= s_hi;
                    dre_r_reg   <= 32'(n_re[62:32]);
                    dim_r_reg   <= 32'(n_im[62:32]);
                    dre_n_reg   <= n_re[31:0];
                    dim_n_reg   <= n_im[31:0];
                    step_reg    <= '0;
                    state_reg   <= S_R_DIV;
                end
                S_R_DIV: begin
                    dre_r_reg <= dre_ge ? 32'(dre_r2 - {1'b0, s_reg}) : dre_r2[31:0];
                    dim_r_reg <= dim_ge ? 32'(dim_r2 - {1'b0, s_reg}) : dim_r2[31:0];
                    dre_q_reg <= {dre_q_reg[30:0], dre_ge};
                    dim_q_reg <= {dim_q_reg[30:0], dim_ge};
                    dre_n_reg <= dre_n_reg << 1;
                    dim_n_reg <= dim_n_reg << 1;
                    step_reg  <= step_reg + 1'b1;
                    if (&step_reg) begin
                        state_reg <= S_R_WR;
                    end
                end
                S_R_WR: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (last_ent) begin
                        bit_reg   <= outc_reg;
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_R_RD;
                    end
                end
                // probability read
                S_P_RD: begin
                    state_reg <= S_P_MUL;
                end
                S_P_MUL: begin
                    state_reg <= S_P_SUM;
                end
                S_P_SUM: begin
                    prob_reg  <= to_q31(ACC_W'(mag));
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_DONE && (!m_valid_reg || m_tready)) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= {4'd0, prob_reg, bit_reg, sts_reg};
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qc_reg <= 4'd1;
        end else if (psel && penable && pwrite && paddr[2] == REG_QUBIT_COUNT) begin
            qc_reg <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_QUBIT_COUNT) ? {28'd0, qc_reg} : 32'd0;

`ifndef NO_ASSERTIONS
    // reset starts the clearing sweep, so no beat right after it
    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("beat accepted during clearing sweep");

    // first write of a pair goes to the entry whose target bit is zero
    a_pair_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_G_P4) |-> ((ram_waddr & tb) == '0))
        else $error("pair low write has target bit set");

    // renormalization never divides by zero
    a_root_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_R_LD) |-> (s_reg != '0))
        else $error("zero square root in renormalize");

    // read and write never hit the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("ram read and write collide");
`endif

endmodule
